// ----- hdl/gnos_pkg.sv -----
// ----------------------------------------------------------------------------
// gnos_pkg
// Shared types and constants of the grid nearest obstacle search block.
// ----------------------------------------------------------------------------
package gnos_pkg;

    localparam int DIM_W     = 9;
    localparam int LIN_W     = 18;
    localparam int DIST_W    = 13;
    localparam int SQ_W      = 12;
    localparam int COST_W    = 8;
    localparam int RAD_W     = 6;
    localparam int IDX_W     = 16;
    localparam int COORD_W   = 16;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [DIM_W-1:0]         RST_GRID_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]         RST_GRID_HEIGHT = 9'd256;
    localparam logic signed [COST_W-1:0] RST_THRESHOLD   = 8'sd100;
    localparam logic [RAD_W-1:0]         RST_RADIUS      = 6'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH         = 2'd0,
        CFG_GRID_HEIGHT        = 2'd1,
        CFG_OBSTACLE_THRESHOLD = 2'd2,
        CFG_SEARCH_RADIUS      = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BOUNDS,
        ST_BASE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic write;
        logic capture;
        logic check;
        logic bounds;
        logic base;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic in_map;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

// ----- hdl/gnos_if.sv -----
// ----------------------------------------------------------------------------
// gnos_if
// Valid/ready channels of the grid nearest obstacle search block.
// ----------------------------------------------------------------------------
interface gnos_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic [gnos_pkg::IDX_W-1:0]           cell_index;
    logic signed [gnos_pkg::COST_W-1:0]   cell_cost;
    logic signed [gnos_pkg::COORD_W-1:0]  query_col;
    logic signed [gnos_pkg::COORD_W-1:0]  query_row;

    modport source (
        output valid, mode, cell_index, cell_cost, query_col, query_row,
        input  ready
    );
    modport sink (
        input  valid, mode, cell_index, cell_cost, query_col, query_row,
        output ready
    );
endinterface

interface gnos_out_if;
    logic                        valid;
    logic                        ready;
    logic                        in_map;
    logic                        found;
    logic [gnos_pkg::DIST_W-1:0] min_dist_sq;

    modport source (
        output valid, in_map, found, min_dist_sq,
        input  ready
    );
    modport sink (
        input  valid, in_map, found, min_dist_sq,
        output ready
    );
endinterface

// ----- hdl/gnos_ctrl.sv -----
// ----------------------------------------------------------------------------
// gnos_ctrl
// Sequencer of the search: query check, window setup, cell scan, result.
// ----------------------------------------------------------------------------
module gnos_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_mode,
    output logic           in_ready,
    input  gnos_pkg::sts_t sts,
    output gnos_pkg::cmd_t cmd
);

    gnos_pkg::state_t state_reg;
    gnos_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gnos_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gnos_pkg::ST_IDLE:
            begin
                if (in_valid && (in_mode == gnos_pkg::MODE_QUERY))
                begin
                    state_next = gnos_pkg::ST_CHECK;
                end
            end
            gnos_pkg::ST_CHECK:
            begin
                state_next = sts.in_map ? gnos_pkg::ST_BOUNDS : gnos_pkg::ST_DONE;
            end
            gnos_pkg::ST_BOUNDS:
            begin
                state_next = gnos_pkg::ST_BASE;
            end
            gnos_pkg::ST_BASE:
            begin
                state_next = gnos_pkg::ST_SCAN;
            end
            gnos_pkg::ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = gnos_pkg::ST_DRAIN;
                end
            end
            gnos_pkg::ST_DRAIN:
            begin
                state_next = gnos_pkg::ST_DONE;
            end
            gnos_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = gnos_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gnos_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            gnos_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.write   = in_valid && (in_mode == gnos_pkg::MODE_WRITE);
                cmd.capture = in_valid && (in_mode == gnos_pkg::MODE_QUERY);
            end
            gnos_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            gnos_pkg::ST_BOUNDS:
            begin
                cmd.bounds = 1'b1;
            end
            gnos_pkg::ST_BASE:
            begin
                cmd.base = 1'b1;
            end
            gnos_pkg::ST_SCAN:
            begin
                cmd.step = 1'b1;
            end
            gnos_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            gnos_pkg::ST_DONE:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/gnos_dp.sv -----
// ----------------------------------------------------------------------------
// gnos_dp
// Datapath: settings, cost memory, window counters, distance and best keeper.
// ----------------------------------------------------------------------------
module gnos_dp #(
    parameter int MAX_CELLS  = 65536,
    parameter int MAX_RADIUS = 63
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  gnos_pkg::cmd_t                       cmd,
    output gnos_pkg::sts_t                       sts,
    input  logic [gnos_pkg::IDX_W-1:0]           cell_index,
    input  logic signed [gnos_pkg::COST_W-1:0]   cell_cost,
    input  logic signed [gnos_pkg::COORD_W-1:0]  query_col,
    input  logic signed [gnos_pkg::COORD_W-1:0]  query_row,
    input  logic                                 cfg_we,
    input  logic [gnos_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gnos_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic                                 out_in_map,
    output logic                                 out_found,
    output logic [gnos_pkg::DIST_W-1:0]          out_min_dist_sq
);

    localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int DW    = gnos_pkg::DIM_W;
    localparam int LW    = gnos_pkg::LIN_W;
    localparam int RW    = gnos_pkg::RAD_W;
    localparam int CW    = gnos_pkg::COST_W;
    localparam int QW    = gnos_pkg::COORD_W;
    localparam int SW    = gnos_pkg::SQ_W;
    localparam int TW    = gnos_pkg::DIST_W;

    logic [DW-1:0]        width_reg;
    logic [DW-1:0]        height_reg;
    logic signed [CW-1:0] thr_reg;
    logic [RW-1:0]        radius_reg;

    logic signed [QW-1:0] col_reg;
    logic signed [QW-1:0] row_reg;
    logic                 in_map_reg;
    logic [DW-1:0]        x_lo_reg;
    logic [DW-1:0]        x_hi_reg;
    logic [DW-1:0]        y_lo_reg;
    logic [DW-1:0]        y_hi_reg;
    logic [DW-1:0]        cx_reg;
    logic [DW-1:0]        cy_reg;
    logic [LW-1:0]        base_reg;

    logic signed [CW-1:0] mem [MAX_CELLS];
    logic signed [CW-1:0] rd_data_reg;
    logic                 s1_v_reg;
    logic [TW-1:0]        s1_d_reg;
    logic                 found_reg;
    logic [TW-1:0]        best_reg;

    logic                 out_valid_reg;
    logic                 out_in_map_reg;
    logic                 out_found_reg;
    logic [TW-1:0]        out_dist_reg;

    logic                 in_map;
    logic [RW-1:0]        r_eff;
    logic [DW-1:0]        col9;
    logic [DW-1:0]        row9;
    logic [DW-1:0]        r9;
    logic [DW:0]          x_sum;
    logic [DW:0]          y_sum;
    logic [DW-1:0]        wm1;
    logic [DW-1:0]        hm1;
    logic [DW-1:0]        x_lo_next;
    logic [DW-1:0]        x_hi_next;
    logic [DW-1:0]        y_lo_next;
    logic [DW-1:0]        y_hi_next;
    logic [DW-1:0]        dx9;
    logic [DW-1:0]        dy9;
    logic [SW-1:0]        dx_sq;
    logic [SW-1:0]        dy_sq;
    logic [TW-1:0]        d_next;
    logic [LW-1:0]        lin;
    logic                 lin_ok;
    logic [AW-1:0]        rd_addr;
    logic                 wr_ok;
    logic [AW-1:0]        wr_addr;
    logic                 hit;

    // settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gnos_pkg::RST_GRID_WIDTH;
            height_reg <= gnos_pkg::RST_GRID_HEIGHT;
            thr_reg    <= gnos_pkg::RST_THRESHOLD;
            radius_reg <= gnos_pkg::RST_RADIUS;
        end
        else if (cfg_we)
        begin
            unique case (gnos_pkg::cfg_idx_t'(cfg_index))
                gnos_pkg::CFG_GRID_WIDTH:         width_reg  <= cfg_wdata;
                gnos_pkg::CFG_GRID_HEIGHT:        height_reg <= cfg_wdata;
                gnos_pkg::CFG_OBSTACLE_THRESHOLD: thr_reg    <= $signed(cfg_wdata[CW-1:0]);
                gnos_pkg::CFG_SEARCH_RADIUS:      radius_reg <= cfg_wdata[RW-1:0];
                default:                          width_reg  <= width_reg;
            endcase
        end
    end

    // query cell check and window bounds
    assign in_map = !col_reg[QW-1] && (col_reg[QW-2:0] < (QW-1)'(width_reg))
                 && !row_reg[QW-1] && (row_reg[QW-2:0] < (QW-1)'(height_reg));

    assign r_eff = (32'(radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : radius_reg;
    assign col9  = col_reg[DW-1:0];
    assign row9  = row_reg[DW-1:0];
    assign r9    = DW'(r_eff);
    assign wm1   = width_reg - DW'(1);
    assign hm1   = height_reg - DW'(1);
    assign x_sum = (DW+1)'(col9) + (DW+1)'(r9);
    assign y_sum = (DW+1)'(row9) + (DW+1)'(r9);

    assign x_lo_next = (col9 >= r9) ? (col9 - r9) : '0;
    assign y_lo_next = (row9 >= r9) ? (row9 - r9) : '0;
    assign x_hi_next = (x_sum > (DW+1)'(wm1)) ? wm1 : x_sum[DW-1:0];
    assign y_hi_next = (y_sum > (DW+1)'(hm1)) ? hm1 : y_sum[DW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg <= query_col;
            row_reg <= query_row;
        end
        if (cmd.check)
        begin
            in_map_reg <= in_map;
        end
        if (cmd.bounds)
        begin
            x_lo_reg <= x_lo_next;
            x_hi_reg <= x_hi_next;
            y_lo_reg <= y_lo_next;
            y_hi_reg <= y_hi_next;
        end
    end

    // window walk, row base advances by the width
    always_ff @(posedge clk)
    begin
        if (cmd.base)
        begin
            base_reg <= LW'(y_lo_reg) * LW'(width_reg);
            cx_reg   <= x_lo_reg;
            cy_reg   <= y_lo_reg;
        end
        else if (cmd.step)
        begin
            if (cx_reg == x_hi_reg)
            begin
                cx_reg   <= x_lo_reg;
                cy_reg   <= cy_reg + DW'(1);
                base_reg <= base_reg + LW'(width_reg);
            end
            else
            begin
                cx_reg <= cx_reg + DW'(1);
            end
        end
    end

    assign dx9    = (cx_reg >= col9) ? (cx_reg - col9) : (col9 - cx_reg);
    assign dy9    = (cy_reg >= row9) ? (cy_reg - row9) : (row9 - cy_reg);
    assign dx_sq  = {{(SW-RW){1'b0}}, dx9[RW-1:0]} * {{(SW-RW){1'b0}}, dx9[RW-1:0]};
    assign dy_sq  = {{(SW-RW){1'b0}}, dy9[RW-1:0]} * {{(SW-RW){1'b0}}, dy9[RW-1:0]};
    assign d_next = TW'(dx_sq) + TW'(dy_sq);

    assign lin     = base_reg + LW'(cx_reg);
    assign lin_ok  = 32'(lin) < MAX_CELLS;
    assign rd_addr = AW'(lin);
    assign wr_ok   = 32'(cell_index) < MAX_CELLS;
    assign wr_addr = AW'(cell_index);

    // cost memory
    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_ok)
        begin
            mem[wr_addr] <= cell_cost;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        s1_d_reg <= d_next;
    end

    assign hit = s1_v_reg && (rd_data_reg >= thr_reg)
              && (!found_reg || (s1_d_reg < best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.step && lin_ok;
            if (cmd.capture)
            begin
                found_reg <= 1'b0;
            end
            else if (hit)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            best_reg <= '0;
        end
        else if (hit)
        begin
            best_reg <= s1_d_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_in_map_reg <= in_map_reg;
            out_found_reg  <= found_reg;
            out_dist_reg   <= found_reg ? best_reg : '0;
        end
    end

    assign sts.in_map    = in_map;
    assign sts.scan_last = (cx_reg == x_hi_reg) && (cy_reg == y_hi_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_in_map      = out_in_map_reg;
    assign out_found       = out_found_reg;
    assign out_min_dist_sq = out_dist_reg;

`ifndef SYNTHESIS
    a_step_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (cx_reg >= x_lo_reg) && (cx_reg <= x_hi_reg)
                  && (cy_reg >= y_lo_reg) && (cy_reg <= y_hi_reg))
        else $error("scan position outside window");

    a_read_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg |-> $past(cmd.step))
        else $error("cell compare without a scan read");

    a_best_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg && $past(found_reg) && !$past(cmd.capture) |-> best_reg <= $past(best_reg))
        else $error("best distance grew during a scan");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("result register overwritten");
`endif

endmodule

// ----- hdl/grid_nearest_obstacle_search.sv -----
// ----------------------------------------------------------------------------
// grid_nearest_obstacle_search
// Occupancy cost grid with nearest obstacle queries over a square window.
// ----------------------------------------------------------------------------
// A write item stores one cost and gives no result. A query item whose cell
// is off the grid gives its result without a scan. A query inside the grid
// scans the window clipped to the grid, one cell per cycle through the single
// read port of the cost memory; the window holds at most (2r+1)^2 cells for
// radius r. The next item is taken as soon as the result sits in the output
// register. The distance is a squared count of cells; cells never written
// must not fall inside a query window.
module grid_nearest_obstacle_search #(
    parameter int MAX_CELLS  = 65536,
    parameter int MAX_RADIUS = 63
) (
    input  logic                                clk,
    input  logic                                rst_n,
    gnos_in_if.sink                             in_ch,
    gnos_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [gnos_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gnos_pkg::CFG_W-1:0]          cfg_wdata
);

    gnos_pkg::cmd_t cmd;
    gnos_pkg::sts_t sts;
    logic           in_ready;

    gnos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_mode  (in_ch.mode),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gnos_dp #(
        .MAX_CELLS  (MAX_CELLS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cell_index      (in_ch.cell_index),
        .cell_cost       (in_ch.cell_cost),
        .query_col       (in_ch.query_col),
        .query_row       (in_ch.query_row),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .out_in_map      (out_ch.in_map),
        .out_found       (out_ch.found),
        .out_min_dist_sq (out_ch.min_dist_sq)
    );

    assign in_ch.ready = in_ready;

endmodule
